>>> rtl/core/rectangle_tile_partitioner_top_macros.svh
// Assertion helpers used by the tile partitioner controller.
`ifndef RECTANGLE_TILE_PARTITIONER_TOP_MACROS_SVH
`define RECTANGLE_TILE_PARTITIONER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtp assertion failed");

// Next-cycle implication, disabled during reset.
`define RTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtp assertion failed");

`endif

>>> rtl/core/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the tile partitioner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_BUDGET = 3'd1;
  localparam logic [2:0] ST_NO_BANDS  = 3'd2;
  localparam logic [2:0] ST_NO_BYTES  = 3'd3;
  localparam logic [2:0] ST_TOO_SMALL = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  localparam logic [1:0] CFG_MAX_BYTES = 2'd0;
  localparam logic [1:0] CFG_BANDS     = 2'd1;
  localparam logic [1:0] CFG_BPP       = 2'd2;
  localparam logic [1:0] CFG_OVERLAP   = 2'd3;

  localparam logic [63:0] MAX_BYTES_RST = 64'd1048576;
  localparam int          MIN_PIXELS    = 4;

  localparam logic [1:0] MSEL_PAD   = 2'd0;
  localparam logic [1:0] MSEL_BANDS = 2'd1;
  localparam logic [1:0] MSEL_BYTES = 2'd2;

  typedef struct packed {
    logic       load;
    logic       fail;
    logic       next;
    logic       mul_go;
    logic [1:0] mul_sel;
    logic       halve;
    logic       div_go;
    logic       div_row;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic       opcode;
    logic [2:0] chk;
    logic       mul_done;
    logic       div_done;
    logic       size_stop;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rtp_if.sv
// ----------------------------------------------------------------------------
// rtp_req_if / rtp_rsp_if
// Request and response channels of the tile partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtp_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] ul_x;
  logic signed [31:0] ul_y;
  logic signed [31:0] lr_x;
  logic signed [31:0] lr_y;
  modport source (output valid, opcode, ul_x, ul_y, lr_x, lr_y, input ready);
  modport sink (input valid, opcode, ul_x, ul_y, lr_x, lr_y, output ready);
endinterface

interface rtp_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [31:0]        tiles_across;
  logic [31:0]        tiles_down;
  logic signed [31:0] tile_ul_x;
  logic signed [31:0] tile_ul_y;
  logic signed [31:0] tile_lr_x;
  logic signed [31:0] tile_lr_y;
  logic               last_tile;
  modport source (output valid, status, tiles_across, tiles_down, tile_ul_x, tile_ul_y,
                  tile_lr_x, tile_lr_y, last_tile, input ready);
  modport sink (input valid, status, tiles_across, tiles_down, tile_ul_x, tile_ul_y,
                tile_lr_x, tile_lr_y, last_tile, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rtp_mul.sv
// ----------------------------------------------------------------------------
// rtp_mul
// Bit-serial saturating multiplier: 64-bit operand times a BW-bit operand.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_mul #(
  parameter int BW = 34
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   a,
  input  wire logic [BW-1:0] b,
  output logic               done,
  output logic [63:0]        p
);

  localparam int CW = $clog2(BW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [63:0]   acc;
  logic          ovf;
  logic [63:0]   areg;
  logic [BW-1:0] breg;
  logic [64:0]   sum;

  // Horner form, MSB of b first; any carry past bit 63 sticks as saturation.
  assign sum = {1'b0, acc[62:0], 1'b0} + (breg[BW-1] ? {1'b0, areg} : 65'd0);
  assign p   = ovf ? '1 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
        acc  <= '0;
        ovf  <= 1'b0;
        areg <= a;
        breg <= b;
      end else if (busy) begin
        acc  <= sum[63:0];
        ovf  <= ovf | acc[63] | sum[64];
        breg <= breg << 1;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rtp_div.sv
// ----------------------------------------------------------------------------
// rtp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_div #(
  parameter int N = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] n,
  input  wire logic [N-1:0] d,
  output logic              done,
  output logic [N-1:0]      q,
  output logic [N-1:0]      r
);

  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  dreg;
  logic [N:0]    sh;
  logic [N:0]    diff;
  logic          take;

  assign sh   = {r, q[N-1]};
  assign diff = sh - {1'b0, dreg};
  assign take = (sh >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
        q    <= n;
        r    <= '0;
        dreg <= d;
      end else if (busy) begin
        r   <= take ? diff[N-1:0] : sh[N-1:0];
        q   <= {q[N-2:0], take};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rtp_datapath.sv
// ----------------------------------------------------------------------------
// rtp_datapath
// Settings, partition state, size test, tile counts and tile output.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_datapath #(
  parameter int COORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire rtp_pkg::cmd_t      cmd,
  output rtp_pkg::stat_t          stat,
  input  wire logic               opcode,
  input  wire logic signed [31:0] ul_x,
  input  wire logic signed [31:0] ul_y,
  input  wire logic signed [31:0] lr_x,
  input  wire logic signed [31:0] lr_y,
  output logic [2:0]              status,
  output logic [31:0]             tiles_across,
  output logic [31:0]             tiles_down,
  output logic signed [31:0]      tile_ul_x,
  output logic signed [31:0]      tile_ul_y,
  output logic signed [31:0]      tile_lr_x,
  output logic signed [31:0]      tile_lr_y,
  output logic                    last_tile
);

  localparam int CB = COORD_BITS;
  localparam int SW = CB + 1;
  localparam int PW = ((SW > 17) ? SW : 17) + 1;
  localparam int XW = PW + 3;
  localparam logic signed [XW-1:0] ONE_X = 1;

  logic [63:0] max_bytes;
  logic [15:0] band_count;
  logic [3:0]  bytes_per_pixel;
  logic [15:0] overlap_pixels;

  logic signed [CB-1:0] ulx, uly, lrx, lry;
  logic [SW-1:0] w, h, tw, th, xoff, yoff;
  logic [31:0]   across, down, col, row;
  logic          pending;
  logic          ov_en;

  // ---- settings check
  logic [19:0] per_pixel;
  logic [2:0]  chk;
  assign per_pixel = 20'(band_count) * 20'(bytes_per_pixel);
  always_comb begin
    priority if (max_bytes == 64'd0) chk = rtp_pkg::ST_NO_BUDGET;
    else if (band_count == 16'd0) chk = rtp_pkg::ST_NO_BANDS;
    else if (bytes_per_pixel == 4'd0) chk = rtp_pkg::ST_NO_BYTES;
    else if (max_bytes < 64'(per_pixel) * 64'(rtp_pkg::MIN_PIXELS))
      chk = rtp_pkg::ST_TOO_SMALL;
    else chk = rtp_pkg::ST_OK;
  end

  // ---- side lengths of the incoming rectangle
  logic signed [SW-1:0] dx, dy;
  logic [SW-1:0] w_n, h_n;
  assign dx  = SW'(signed'(lr_x[CB-1:0])) - SW'(signed'(ul_x[CB-1:0]));
  assign dy  = SW'(signed'(lr_y[CB-1:0])) - SW'(signed'(ul_y[CB-1:0]));
  assign w_n = (dx[SW-1] ? -dx : dx) + SW'(1);
  assign h_n = (dy[SW-1] ? -dy : dy) + SW'(1);

  // ---- byte size of the current tile
  logic [PW-1:0] pad, pw_a, pw_b;
  logic [63:0]   mul_a, mul_p;
  logic [PW-1:0] mul_b;
  logic          mul_done;
  assign pad  = ov_en ? PW'({overlap_pixels, 1'b0}) : '0;
  assign pw_a = PW'(tw) + pad;
  assign pw_b = PW'(th) + pad;
  always_comb begin
    unique case (cmd.mul_sel)
      rtp_pkg::MSEL_PAD: begin
        mul_a = 64'(pw_a);
        mul_b = pw_b;
      end
      rtp_pkg::MSEL_BANDS: begin
        mul_a = mul_p;
        mul_b = PW'(band_count);
      end
      rtp_pkg::MSEL_BYTES: begin
        mul_a = mul_p;
        mul_b = PW'(bytes_per_pixel);
      end
      default: begin
        mul_a = mul_p;
        mul_b = '0;
      end
    endcase
  end

  rtp_mul #(.BW(PW)) u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  // ---- tile counts
  logic [SW-1:0] q, r;
  logic [SW:0]   ceil_c;
  logic [63:0]   ceil_w;
  logic [31:0]   ceil_sat;
  logic          div_done;
  rtp_div #(.N(SW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_go),
    .n(cmd.div_row ? h : w), .d(cmd.div_row ? th : tw),
    .done(div_done), .q(q), .r(r)
  );
  assign ceil_c   = {1'b0, q} + {{SW{1'b0}}, (r != '0)};
  assign ceil_w   = 64'(ceil_c);
  assign ceil_sat = (ceil_w > 64'hFFFF_FFFF) ? '1 : ceil_w[31:0];

  // ---- next tile geometry
  logic signed [XW-1:0] ulx_e, uly_e, lrx_e, lry_e, ov_s;
  logic signed [XW-1:0] x0, y0, x1c, y1c, x1, y1;
  logic col_wrap, row_wrap, last;
  assign ulx_e = XW'(ulx);
  assign uly_e = XW'(uly);
  assign lrx_e = XW'(lrx);
  assign lry_e = XW'(lry);
  assign ov_s  = $signed(XW'(overlap_pixels));
  assign x0  = (col == 32'd0) ? ulx_e : ulx_e + $signed(XW'(xoff)) - ov_s;
  assign y0  = (row == 32'd0) ? uly_e : uly_e + $signed(XW'(yoff)) - ov_s;
  assign x1c = ulx_e + $signed(XW'(xoff)) + $signed(XW'(tw)) - ONE_X + ov_s;
  assign y1c = uly_e + $signed(XW'(yoff)) + $signed(XW'(th)) - ONE_X + ov_s;
  assign x1  = (x1c > lrx_e) ? lrx_e : x1c;
  assign y1  = (y1c > lry_e) ? lry_e : y1c;
  assign col_wrap = ({1'b0, col} + 33'd1) >= {1'b0, across};
  assign row_wrap = ({1'b0, row} + 33'd1) >= {1'b0, down};
  assign last     = col_wrap && row_wrap;

  assign stat.opcode    = opcode;
  assign stat.chk       = chk;
  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.size_stop = (mul_p <= max_bytes) ||
                          (ov_en && tw == SW'(1) && th == SW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes       <= rtp_pkg::MAX_BYTES_RST;
      band_count      <= 16'd1;
      bytes_per_pixel <= 4'd1;
      overlap_pixels  <= 16'd0;
      pending         <= 1'b0;
      across          <= '0;
      down            <= '0;
      col             <= '0;
      row             <= '0;
      xoff            <= '0;
      yoff            <= '0;
      ov_en           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rtp_pkg::CFG_MAX_BYTES: max_bytes       <= cfg_data;
          rtp_pkg::CFG_BANDS:     band_count      <= cfg_data[15:0];
          rtp_pkg::CFG_BPP:       bytes_per_pixel <= cfg_data[3:0];
          rtp_pkg::CFG_OVERLAP:   overlap_pixels  <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        ulx     <= ul_x[CB-1:0];
        uly     <= ul_y[CB-1:0];
        lrx     <= lr_x[CB-1:0];
        lry     <= lr_y[CB-1:0];
        w       <= w_n;
        h       <= h_n;
        tw      <= w_n;
        th      <= h_n;
        across  <= '0;
        down    <= '0;
        col     <= '0;
        row     <= '0;
        xoff    <= '0;
        yoff    <= '0;
        pending <= 1'b0;
        ov_en   <= 1'b0;
      end

      // Halve the longer side, rounding up; the width goes on a tie.
      if (cmd.halve) begin
        ov_en <= 1'b1;
        if (th > tw) th <= SW'(({1'b0, th} + (SW+1)'(1)) >> 1);
        else tw <= SW'(({1'b0, tw} + (SW+1)'(1)) >> 1);
      end

      if (div_done) begin
        if (cmd.div_row) down <= ceil_sat;
        else across <= ceil_sat;
      end

      if (cmd.finish) begin
        pending      <= 1'b1;
        status       <= rtp_pkg::ST_OK;
        tiles_across <= across;
        tiles_down   <= down;
        tile_ul_x    <= '0;
        tile_ul_y    <= '0;
        tile_lr_x    <= '0;
        tile_lr_y    <= '0;
        last_tile    <= 1'b0;
      end

      if (cmd.fail) begin
        status       <= chk;
        tiles_across <= '0;
        tiles_down   <= '0;
        tile_ul_x    <= '0;
        tile_ul_y    <= '0;
        tile_lr_x    <= '0;
        tile_lr_y    <= '0;
        last_tile    <= 1'b0;
      end

      if (cmd.next) begin
        if (!pending) begin
          status       <= rtp_pkg::ST_NONE;
          tiles_across <= '0;
          tiles_down   <= '0;
          tile_ul_x    <= '0;
          tile_ul_y    <= '0;
          tile_lr_x    <= '0;
          tile_lr_y    <= '0;
          last_tile    <= 1'b0;
        end else begin
          status       <= rtp_pkg::ST_OK;
          tiles_across <= across;
          tiles_down   <= down;
          tile_ul_x    <= 32'(signed'(x0[CB-1:0]));
          tile_ul_y    <= 32'(signed'(y0[CB-1:0]));
          tile_lr_x    <= 32'(signed'(x1[CB-1:0]));
          tile_lr_y    <= 32'(signed'(y1[CB-1:0]));
          last_tile    <= last;
          if (last) begin
            pending <= 1'b0;
            across  <= '0;
            down    <= '0;
            col     <= '0;
            row     <= '0;
            xoff    <= '0;
            yoff    <= '0;
          end else if (col_wrap) begin
            col  <= '0;
            xoff <= '0;
            row  <= row + 32'd1;
            yoff <= yoff + th;
          end else begin
            col  <= col + 32'd1;
            xoff <= xoff + tw;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rtp_ctrl.sv
// ----------------------------------------------------------------------------
// rtp_ctrl
// Sequencer for start and next requests of the tile partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_tile_partitioner_top_macros.svh"

module rtp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rtp_pkg::stat_t stat,
  output rtp_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_M1    = 4'd2;
  localparam logic [3:0] S_W1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_W2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_W3    = 4'd7;
  localparam logic [3:0] S_FIT   = 4'd8;
  localparam logic [3:0] S_D1    = 4'd9;
  localparam logic [3:0] S_WD1   = 4'd10;
  localparam logic [3:0] S_D2    = 4'd11;
  localparam logic [3:0] S_WD2   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state, state_next;
  logic       start_take;
  logic       mul_wait;
  logic       div_wait;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  assign start_take = in_valid && in_ready && (stat.opcode == rtp_pkg::OP_START);
  assign mul_wait   = (state == S_W1) || (state == S_W2) || (state == S_W3);
  assign div_wait   = (state == S_WD1) || (state == S_WD2);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = rtp_pkg::MSEL_PAD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.opcode == rtp_pkg::OP_NEXT) begin
            cmd.next   = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.chk != rtp_pkg::ST_OK) begin
          cmd.fail   = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_M1;
        end
      end
      S_M1: begin
        cmd.mul_go = 1'b1;
        state_next = S_W1;
      end
      S_W1: if (stat.mul_done) state_next = S_M2;
      S_M2: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = rtp_pkg::MSEL_BANDS;
        state_next  = S_W2;
      end
      S_W2: if (stat.mul_done) state_next = S_M3;
      S_M3: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = rtp_pkg::MSEL_BYTES;
        state_next  = S_W3;
      end
      S_W3: if (stat.mul_done) state_next = S_FIT;
      S_FIT: begin
        if (stat.size_stop) begin
          state_next = S_D1;
        end else begin
          cmd.halve  = 1'b1;
          state_next = S_M1;
        end
      end
      S_D1: begin
        cmd.div_go = 1'b1;
        state_next = S_WD1;
      end
      S_WD1: if (stat.div_done) state_next = S_D2;
      S_D2: begin
        cmd.div_go  = 1'b1;
        cmd.div_row = 1'b1;
        state_next  = S_WD2;
      end
      S_WD2: begin
        cmd.div_row = 1'b1;
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `RTP_ASSERT_NEXT(a_start_checks, clk, rst, start_take, state == S_CHECK)
  `RTP_ASSERT_NOW(a_mul_done_waited, clk, rst, stat.mul_done, mul_wait)
  `RTP_ASSERT_NOW(a_div_done_waited, clk, rst, stat.div_done, div_wait)
  `RTP_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid)

endmodule

`default_nettype wire

>>> rtl/core/rectangle_tile_partitioner_top.sv
// A next request is answered in the cycle after it is accepted. A start request first
// passes the settings check, and a failed check is answered right after it. Otherwise it
// runs one or more size tests, each made of three passes of a bit-serial saturating
// multiplier with a PW-bit operand and a compare, with PW = max(COORD_BITS+1, 17)+1, which
// is 34 for 32-bit coordinates. The first test covers the whole rectangle and each further
// one follows a halving, for at most 2*COORD_BITS+1 tests. Two restoring divisions then give
// the tile counts, and the finish state posts the response.
// One request is in flight at a time; the response is held until taken, and the next
// request is accepted once it has been taken.
// ----------------------------------------------------------------------------
// rectangle_tile_partitioner_top
// Splits a rectangle into byte-budgeted tiles and hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_tile_partitioner_top #(
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  rtp_req_if.sink          req,
  rtp_rsp_if.source        rsp
);

  rtp_pkg::cmd_t  cmd;
  rtp_pkg::stat_t stat;

  rtp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  rtp_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat),
    .opcode(req.opcode), .ul_x(req.ul_x), .ul_y(req.ul_y),
    .lr_x(req.lr_x), .lr_y(req.lr_y),
    .status(rsp.status), .tiles_across(rsp.tiles_across), .tiles_down(rsp.tiles_down),
    .tile_ul_x(rsp.tile_ul_x), .tile_ul_y(rsp.tile_ul_y),
    .tile_lr_x(rsp.tile_lr_x), .tile_lr_y(rsp.tile_lr_y),
    .last_tile(rsp.last_tile)
  );

endmodule

`default_nettype wire

>>> tb/tb_rectangle_tile_partitioner_top.sv
// ----------------------------------------------------------------------------
// Tile partitioner testbench
// Drives start and next requests through the request channel, predicts each
// response with a behavioral model of the partitioner, and compares every
// response field by field. Configuration changes only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rectangle_tile_partitioner_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               opcode;
    logic signed [31:0] ul_x;
    logic signed [31:0] ul_y;
    logic signed [31:0] lr_x;
    logic signed [31:0] lr_y;
  } tile_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] tiles_across;
    logic [31:0] tiles_down;
    logic [31:0] tile_ul_x;
    logic [31:0] tile_ul_y;
    logic [31:0] tile_lr_x;
    logic [31:0] tile_lr_y;
    logic        last_tile;
  } tile_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rtp_pkg::CFG_MAX_BYTES;
  logic [63:0] cfg_data = '0;

  rtp_req_if req ();
  rtp_rsp_if rsp ();

  rectangle_tile_partitioner_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always #4 clk = ~clk;

  // Shadow copy of the registers and the partition state.
  logic [63:0] budget;
  logic [63:0] bands;
  logic [63:0] sample_bytes;
  logic [63:0] overlap;
  longint      corner [4];
  logic [63:0] tile_w, tile_h, across, down, col, row;
  bit          active;

  tile_req_t request_q [$];
  tile_rsp_t expected_q [$];
  int        tx_idle = 0;
  int        rx_idle = 0;
  int        hold_left = 0;
  bit        stall_req = 0;
  int        errors = 0;
  int        starts = 0;
  int        nexts = 0;
  int        checked = 0;

  function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
    if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) return 64'hFFFF_FFFF_FFFF_FFFF;
    return a * b;
  endfunction

  function automatic logic [63:0] padded_bytes(logic [63:0] w, logic [63:0] h,
                                               logic [63:0] ov);
    logic [63:0] s;
    s = sat_mul(w + 2 * ov, h + 2 * ov);
    s = sat_mul(s, bands);
    return sat_mul(s, sample_bytes);
  endfunction

  function automatic logic [63:0] span(longint a, longint b);
    return (a > b ? a - b : b - a) + 1;
  endfunction

  function automatic logic [63:0] tiles_needed(logic [63:0] total, logic [63:0] part);
    logic [63:0] n;
    n = total / part + ((total % part) != 0 ? 64'd1 : 64'd0);
    return n > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : n;
  endfunction

  function automatic logic [2:0] start_partition(tile_req_t r);
    logic [63:0] w, h, tw, th;
    active = 0;
    across = 0;
    down = 0;
    col = 0;
    row = 0;
    corner[0] = r.ul_x;
    corner[1] = r.ul_y;
    corner[2] = r.lr_x;
    corner[3] = r.lr_y;
    if (budget == 0) return rtp_pkg::ST_NO_BUDGET;
    if (bands == 0) return rtp_pkg::ST_NO_BANDS;
    if (sample_bytes == 0) return rtp_pkg::ST_NO_BYTES;
    if (budget / (bands * sample_bytes) < rtp_pkg::MIN_PIXELS) return rtp_pkg::ST_TOO_SMALL;
    w = span(corner[2], corner[0]);
    h = span(corner[3], corner[1]);
    tw = w;
    th = h;
    if (padded_bytes(w, h, 0) > budget) begin
      do begin
        if (th > tw) th = th / 2 + th % 2;
        else tw = tw / 2 + tw % 2;
      end while (padded_bytes(tw, th, overlap) > budget && !(tw == 1 && th == 1));
    end
    tile_w = tw;
    tile_h = th;
    across = tiles_needed(w, tw);
    down = tiles_needed(h, th);
    active = 1;
    return rtp_pkg::ST_OK;
  endfunction

  function automatic tile_rsp_t predict_tile(tile_req_t r);
    tile_rsp_t e;
    longint    ov, x0, y0, x1, y1;
    bit        last;
    e = '{default: '0};
    if (r.opcode == rtp_pkg::OP_START) begin
      e.status = start_partition(r);
      e.tiles_across = across[31:0];
      e.tiles_down = down[31:0];
      return e;
    end
    if (!active) begin
      e.status = rtp_pkg::ST_NONE;
      return e;
    end
    ov = longint'(overlap);
    x0 = corner[0] + (col == 0 ? 0 : longint'(col) * longint'(tile_w) - ov);
    y0 = corner[1] + (row == 0 ? 0 : longint'(row) * longint'(tile_h) - ov);
    x1 = corner[0] + (longint'(col) + 1) * longint'(tile_w) - 1 + ov;
    y1 = corner[1] + (longint'(row) + 1) * longint'(tile_h) - 1 + ov;
    if (x1 > corner[2]) x1 = corner[2];
    if (y1 > corner[3]) y1 = corner[3];
    last = (col + 1 >= across) && (row + 1 >= down);
    e.status = rtp_pkg::ST_OK;
    e.tiles_across = across[31:0];
    e.tiles_down = down[31:0];
    e.tile_ul_x = x0[31:0];
    e.tile_ul_y = y0[31:0];
    e.tile_lr_x = x1[31:0];
    e.tile_lr_y = y1[31:0];
    e.last_tile = last;
    if (last) begin
      active = 0;
      col = 0;
      row = 0;
      across = 0;
      down = 0;
    end else begin
      col++;
      if (col >= across) begin
        col = 0;
        row++;
      end
    end
    return e;
  endfunction

  // Request driver: a request stays on the channel until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_q.insert(expected_q.size(),
                          predict_tile('{req.opcode, req.ul_x, req.ul_y,
                                         req.lr_x, req.lr_y}));
        if (req.opcode == rtp_pkg::OP_START) starts++;
        else nexts++;
      end
      if (!req.valid || req.ready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
          tile_req_t r;
          r = request_q.pop_front();
          req.valid <= 1'b1;
          req.opcode <= r.opcode;
          req.ul_x <= r.ul_x;
          req.ul_y <= r.ul_y;
          req.lr_x <= r.lr_x;
          req.lr_y <= r.lr_y;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    req.opcode = rtp_pkg::OP_NEXT;
    req.ul_x = '0;
    req.ul_y = '0;
    req.lr_x = '0;
    req.lr_y = '0;
    req.valid = 1'b0;
    rsp.ready = 1'b0;
  end

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", field, got, want);
  endtask

  // Long receiver hold-off, counted down here while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (stall_req) begin
      stall_req = 0;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response monitor with random and long back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected response", rsp.status, 0);
        end else begin
          tile_rsp_t e;
          e = expected_q.pop_front();
          checked++;
          if (rsp.status !== e.status) report("status", rsp.status, e.status);
          if (rsp.tiles_across !== e.tiles_across)
            report("tiles_across", rsp.tiles_across, e.tiles_across);
          if (rsp.tiles_down !== e.tiles_down)
            report("tiles_down", rsp.tiles_down, e.tiles_down);
          if (rsp.tile_ul_x !== e.tile_ul_x) report("tile_ul_x", rsp.tile_ul_x, e.tile_ul_x);
          if (rsp.tile_ul_y !== e.tile_ul_y) report("tile_ul_y", rsp.tile_ul_y, e.tile_ul_y);
          if (rsp.tile_lr_x !== e.tile_lr_x) report("tile_lr_x", rsp.tile_lr_x, e.tile_lr_x);
          if (rsp.tile_lr_y !== e.tile_lr_y) report("tile_lr_y", rsp.tile_lr_y, e.tile_lr_y);
          if (rsp.last_tile !== e.last_tile) report("last_tile", rsp.last_tile, e.last_tile);
        end
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= $urandom_range(99) >= rx_idle;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      rtp_pkg::CFG_MAX_BYTES: budget = data;
      rtp_pkg::CFG_BANDS:     bands = data[15:0];
      rtp_pkg::CFG_BPP:       sample_bytes = data[3:0];
      default:                overlap = data[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [63:0] b, logic [63:0] n, logic [63:0] s, logic [63:0] o);
    write_reg(rtp_pkg::CFG_MAX_BYTES, b);
    write_reg(rtp_pkg::CFG_BANDS, n);
    write_reg(rtp_pkg::CFG_BPP, s);
    write_reg(rtp_pkg::CFG_OVERLAP, o);
  endtask

  task automatic add(logic op, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                     logic [31:0] d);
    request_q.insert(request_q.size(), '{op, a, b, c, d});
  endtask

  task automatic add_nexts(int n);
    repeat (n) add(rtp_pkg::OP_NEXT, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Waits until every request is sent and answered, then idles before returning.
  task automatic drain();
    while (request_q.size() > 0 || req.valid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_random_start();
    int k;
    logic signed [31:0] x, y;
    k = $urandom_range(3);
    if (k == 0) begin
      x = $urandom_range(64) - 32;
      y = $urandom_range(64) - 32;
      add(rtp_pkg::OP_START, x, y, x + $urandom_range(40), y + $urandom_range(40));
    end else if (k == 1) begin
      x = $urandom_range(65535) - 32768;
      y = $urandom_range(65535) - 32768;
      add(rtp_pkg::OP_START, x, y, x + $urandom_range(2000), y + $urandom_range(2000));
    end else if (k == 2) begin
      add(rtp_pkg::OP_START, $urandom, $urandom, $urandom, $urandom);
    end else begin
      x = $urandom_range(64) - 32;
      y = $urandom_range(64) - 32;
      add(rtp_pkg::OP_START, x, y, x - $urandom_range(30), y - $urandom_range(30));
    end
  endtask

  task automatic random_config();
    logic [63:0] b, n, s, o;
    case ($urandom_range(4))
      0, 1: b = $urandom_range(4096, 4);
      2:    b = $urandom_range(15);
      3:    b = {$urandom, $urandom};
      default: b = rtp_pkg::MAX_BYTES_RST;
    endcase
    case ($urandom_range(9))
      0: n = 0;
      1: n = 16'hFFFF;
      2: n = $urandom_range(65535);
      default: n = $urandom_range(4, 1);
    endcase
    s = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
    o = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(3);
    configure(b, n, s, o);
  endtask

  initial begin
    budget = rtp_pkg::MAX_BYTES_RST;
    bands = 1;
    sample_bytes = 1;
    overlap = 0;
    foreach (corner[i]) corner[i] = 0;
    tile_w = 0;
    tile_h = 0;
    across = 0;
    down = 0;
    col = 0;
    row = 0;
    active = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: next with nothing pending, a single-tile rectangle,
    // swapped corners, the full coordinate range, and a start while active.
    tx_idle = 25;
    rx_idle = 48;
    add_nexts(1);
    add(rtp_pkg::OP_START, 5, 7, 5, 7);
    add_nexts(2);
    add(rtp_pkg::OP_START, 10, 10, -20, -30);
    add_nexts(1);
    add(rtp_pkg::OP_START, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_nexts(3);
    add(rtp_pkg::OP_START, 0, 0, 2047, 1023);
    add_nexts(2);
    drain();

    // Each failed settings check.
    configure(0, 1, 1, 0);
    add(rtp_pkg::OP_START, 0, 0, 3, 3);
    add_nexts(1);
    drain();
    configure(rtp_pkg::MAX_BYTES_RST, 0, 1, 0);
    add(rtp_pkg::OP_START, 0, 0, 3, 3);
    drain();
    configure(rtp_pkg::MAX_BYTES_RST, 1, 0, 0);
    add(rtp_pkg::OP_START, 0, 0, 3, 3);
    drain();
    configure(3, 1, 1, 0);
    add(rtp_pkg::OP_START, 0, 0, 3, 3);
    drain();

    // Largest settings, then an overlap wider than the whole rectangle, placed
    // near the top of the coordinate range.
    configure(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8, 16'hFFFF);
    add(rtp_pkg::OP_START, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_nexts(2);
    drain();
    configure(rtp_pkg::MAX_BYTES_RST, 1, 1, 16'hFFFF);
    add(rtp_pkg::OP_START, 32'h7FFF_FF00, 32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_nexts(4);
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      int added;
      tx_idle = phase < 5 ? 25 : (phase < 10 ? 48 : 0);
      rx_idle = phase < 5 ? 48 : (phase < 10 ? 25 : 0);
      random_config();
      added = 0;
      while (added < 105) begin
        if ($urandom_range(9) < 8) begin
          int n;
          n = $urandom_range(20, 1);
          add_random_start();
          add_nexts(n);
          added += n + 1;
        end else begin
          add(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
          added++;
        end
      end
      if (phase == 3 || phase == 12) begin
        repeat (30) @(posedge clk);
        stall_req = 1;
      end
      drain();
    end

    $display("ran %0d starts and %0d next requests, %0d responses compared",
             starts, nexts, checked);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/rtp_pkg.sv
rtl/core/rtp_if.sv
rtl/core/rtp_mul.sv
rtl/core/rtp_div.sv
rtl/core/rtp_datapath.sv
rtl/core/rtp_ctrl.sv
rtl/core/rectangle_tile_partitioner_top.sv
tb/tb_rectangle_tile_partitioner_top.sv
